// ===== src/pas_pkg.sv =====
// Shared types, codes and default parameters of the pair and run statistics block.
package pas_pkg;

  localparam int unsigned DEF_RUN_CLASSES = 8;
  localparam int unsigned DEF_MAX_RUN     = 256;
  localparam int unsigned DEF_COUNT_WIDTH = 32;

  localparam int unsigned OUT_W      = 32;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned SYM_DEPTH  = 256;
  localparam int unsigned PAIR_W     = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CLASS_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE      = 3'd0,
    MODE_END_BLOCK = 3'd1,
    MODE_CLEAR     = 3'd2,
    MODE_READ_PAIR = 3'd3,
    MODE_READ_BYTE = 3'd4,
    MODE_READ_RUN  = 3'd5
  } mode_e;

  typedef struct packed {
    logic accept;
    logic commit;
    logic sweep_all;
    logic sweep_pb;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_clear;
    logic out_busy;
    logic sweep_last;
  } dp_sts_t;

endpackage

// ===== src/pas_ctrl.sv =====
// Controller state machine: reset sweep, item accept, commit and count clearing sweep.
module pas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pas_pkg::dp_sts_t  sts_i,
  output pas_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   go;

  assign go = !(sts_i.is_read && sts_i.out_busy);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_all = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          cmd_o.commit = 1'b1;
          state_d = sts_i.is_clear ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_pb = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/pas_dp.sv =====
// Datapath: count memories, run tracking registers, saturating update and result register.
module pas_dp #(
  parameter int unsigned RUN_CLASSES = pas_pkg::DEF_RUN_CLASSES,
  parameter int unsigned MAX_RUN     = pas_pkg::DEF_MAX_RUN,
  parameter int unsigned COUNT_WIDTH = pas_pkg::DEF_COUNT_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pas_pkg::ctl_cmd_t           cmd_i,
  output pas_pkg::dp_sts_t            sts_o,
  input  logic [pas_pkg::MODE_W-1:0]  mode_i,
  input  logic [pas_pkg::SYM_W-1:0]   data_byte_i,
  input  logic [pas_pkg::PAIR_W-1:0]  pair_index_i,
  input  logic [pas_pkg::CLASS_W-1:0] run_class_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pas_pkg::OUT_W-1:0]   count_o
);

  localparam int unsigned LEN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned CW    = COUNT_WIDTH;

  // item latched at transfer
  pas_pkg::mode_e                mode_q;
  logic [pas_pkg::PAIR_W-1:0]    pair_addr_q;
  logic [pas_pkg::SYM_W-1:0]     byte_q;
  logic [pas_pkg::SYM_W-1:0]     run_addr_q;
  logic [pas_pkg::CLASS_W-1:0]   cls_q;

  // run tracking
  logic [pas_pkg::SYM_W-1:0] prev_q, prev_d;
  logic [pas_pkg::SYM_W-1:0] sym_q, sym_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic                      started_q, started_d;

  logic [pas_pkg::PAIR_W-1:0] sweep_q;
  logic                       sweeping;

  logic [pas_pkg::PAIR_W-1:0] pair_ra;
  logic [pas_pkg::SYM_W-1:0]  byte_ra;
  logic [pas_pkg::SYM_W-1:0]  run_ra;
  logic [pas_pkg::PAIR_W-1:0] pair_in_addr;

  logic [CW-1:0] pair_mem [1 << pas_pkg::PAIR_W];
  logic [CW-1:0] byte_mem [pas_pkg::SYM_DEPTH];
  logic [CW-1:0] pair_rd_q, byte_rd_q;
  wire  [CW-1:0] bank_rd [RUN_CLASSES];

  logic                     is_byte, do_flush, pair_we, byte_we, load;
  logic [RUN_CLASSES:0]     len_ext;
  logic [RUN_CLASSES-1:0]   bank_we;
  logic [CW-1:0]            run_sel;
  logic [pas_pkg::OUT_W-1:0] pair_out, byte_out, run_out, out_d;
  logic                     out_valid_q;
  logic [pas_pkg::OUT_W-1:0] count_q;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  assign sweeping     = cmd_i.sweep_all || cmd_i.sweep_pb;
  assign pair_in_addr = (pas_pkg::mode_e'(mode_i) == pas_pkg::MODE_READ_PAIR) ? pair_index_i
                                                                              : {prev_q, data_byte_i};
  assign pair_ra = cmd_i.accept ? pair_in_addr : pair_addr_q;
  assign byte_ra = cmd_i.accept ? data_byte_i : byte_q;
  assign run_ra  = !cmd_i.accept ? run_addr_q :
                   (pas_pkg::mode_e'(mode_i) == pas_pkg::MODE_READ_RUN) ? data_byte_i : sym_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q      <= pas_pkg::mode_e'(mode_i);
      pair_addr_q <= pair_in_addr;
      byte_q      <= data_byte_i;
      run_addr_q  <= run_ra;
      cls_q       <= run_class_i;
    end
  end

  // update decision
  always_comb begin
    is_byte   = cmd_i.commit && (mode_q == pas_pkg::MODE_BYTE);
    do_flush  = 1'b0;
    pair_we   = 1'b0;
    byte_we   = is_byte;
    prev_d    = prev_q;
    sym_d     = sym_q;
    len_d     = len_q;
    started_d = started_q;
    if (is_byte) begin
      prev_d = byte_q;
      if (!started_q) begin
        started_d = 1'b1;
        len_d     = LEN_W'(1);
        sym_d     = byte_q;
      end else begin
        pair_we = 1'b1;
        if ((byte_q == sym_q) && (len_q < LEN_W'(MAX_RUN))) begin
          len_d = len_q + LEN_W'(1);
        end else begin
          do_flush = 1'b1;
          len_d    = LEN_W'(1);
          sym_d    = byte_q;
        end
      end
    end else if (cmd_i.commit && (mode_q == pas_pkg::MODE_END_BLOCK)) begin
      do_flush = 1'b1;
      len_d    = '0;
      sym_d    = '0;
    end
  end

  // bit k of the run length feeds class k-1; bit 0 never counts
  assign len_ext = (RUN_CLASSES + 1)'(len_q);
  assign bank_we = do_flush ? len_ext[RUN_CLASSES:1] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      sym_q     <= '0;
      len_q     <= '0;
      started_q <= 1'b0;
      sweep_q   <= '0;
    end else begin
      prev_q    <= prev_d;
      sym_q     <= sym_d;
      len_q     <= len_d;
      started_q <= started_d;
      if (sweeping) sweep_q <= sweep_q + pas_pkg::PAIR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweeping) begin
      pair_mem[sweep_q] <= '0;
    end else if (pair_we) begin
      pair_mem[pair_addr_q] <= sat_inc(pair_rd_q);
    end
    pair_rd_q <= pair_mem[pair_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sweeping) begin
      byte_mem[sweep_q[pas_pkg::SYM_W-1:0]] <= '0;
    end else if (byte_we) begin
      byte_mem[byte_q] <= sat_inc(byte_rd_q);
    end
    byte_rd_q <= byte_mem[byte_ra];
  end

  for (genvar c = 0; c < RUN_CLASSES; c++) begin : g_bank
    logic [CW-1:0] mem [pas_pkg::SYM_DEPTH];
    logic [CW-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (cmd_i.sweep_all) begin
        mem[sweep_q[pas_pkg::SYM_W-1:0]] <= '0;
      end else if (bank_we[c]) begin
        mem[run_addr_q] <= sat_inc(rd_q);
      end
      rd_q <= mem[run_ra];
    end
    assign bank_rd[c] = rd_q;
  end

  always_comb begin
    run_sel = '0;
    for (int c = 0; c < RUN_CLASSES; c++) begin
      if (int'(cls_q) == c) run_sel = bank_rd[c];
    end
  end

  if (CW > pas_pkg::OUT_W) begin : g_clamp
    assign pair_out = (|pair_rd_q[CW-1:pas_pkg::OUT_W]) ? '1 : pair_rd_q[pas_pkg::OUT_W-1:0];
    assign byte_out = (|byte_rd_q[CW-1:pas_pkg::OUT_W]) ? '1 : byte_rd_q[pas_pkg::OUT_W-1:0];
    assign run_out  = (|run_sel[CW-1:pas_pkg::OUT_W]) ? '1 : run_sel[pas_pkg::OUT_W-1:0];
  end else begin : g_ext
    assign pair_out = pas_pkg::OUT_W'(pair_rd_q);
    assign byte_out = pas_pkg::OUT_W'(byte_rd_q);
    assign run_out  = pas_pkg::OUT_W'(run_sel);
  end

  always_comb begin
    case (mode_q)
      pas_pkg::MODE_READ_PAIR: out_d = pair_out;
      pas_pkg::MODE_READ_BYTE: out_d = byte_out;
      pas_pkg::MODE_READ_RUN:  out_d = (int'(cls_q) < RUN_CLASSES) ? run_out : '0;
      default:                 out_d = '0;
    endcase
  end

  assign sts_o.is_read    = (mode_q == pas_pkg::MODE_READ_PAIR) ||
                            (mode_q == pas_pkg::MODE_READ_BYTE) ||
                            (mode_q == pas_pkg::MODE_READ_RUN);
  assign sts_o.is_clear   = (mode_q == pas_pkg::MODE_CLEAR);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.sweep_last = &sweep_q;

  assign load = cmd_i.commit && sts_o.is_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) count_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_RUN))
    else $error("run length above cap");

  a_len_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> started_q)
    else $error("open run before first byte");

  a_started_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started dropped");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && !sweeping))
    else $error("read result lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load)
    else $error("pending result overwritten");

endmodule

// ===== src/pair_and_run_statistics_top.sv =====
// Top level of the pair and run statistics block: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o) carries one item per transfer: a stream
// byte, an end of block, a clear, or a read of a pair, byte or run class count.
// Output channel (out_valid_o/out_ready_i) carries one count per read item.
// Every item has an accept step, which issues the memory reads, and a commit
// step, which updates the count memories or loads the result register. A read
// result is registered in the output register at its commit step. Run class
// counts live in one 256-deep bank per class, so a run flush updates each class
// whose bit is set in the run length, in that same update cycle. A clear item
// additionally sweeps the pair and byte memories one entry per cycle, during
// which no item is taken. After reset the block sweeps all count memories
// before in_ready_o rises. If the receiver stalls, a finished result waits in
// the output register; further non-read items proceed, and a next read item
// holds in its update cycle until the register frees.
module pair_and_run_statistics_top #(
  parameter int unsigned RUN_CLASSES = pas_pkg::DEF_RUN_CLASSES,
  parameter int unsigned MAX_RUN     = pas_pkg::DEF_MAX_RUN,
  parameter int unsigned COUNT_WIDTH = pas_pkg::DEF_COUNT_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pas_pkg::MODE_W-1:0]  mode_i,
  input  logic [pas_pkg::SYM_W-1:0]   data_byte_i,
  input  logic [pas_pkg::PAIR_W-1:0]  pair_index_i,
  input  logic [pas_pkg::CLASS_W-1:0] run_class_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pas_pkg::OUT_W-1:0]   count_o
);

  pas_pkg::ctl_cmd_t cmd;
  pas_pkg::dp_sts_t  sts;

  pas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pas_dp #(
    .RUN_CLASSES (RUN_CLASSES),
    .MAX_RUN     (MAX_RUN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .pair_index_i (pair_index_i),
    .run_class_i  (run_class_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .count_o      (count_o)
  );

endmodule
